// ----- hw/rtl/ess_pkg.sv -----
// Shared types and constants for the encoder step setter and stepper sequencer.
// No dependencies; used by ess_quad_dec and encoder_set_stepper_step_sequencer_core.
package ess_pkg;

  typedef enum logic [2:0] {
    ModeIdle   = 3'b001,
    ModeStep   = 3'b010,
    ModeSettle = 3'b100
  } mode_e;

  localparam logic [1:0] CfgPhaseTicks    = 2'd0;
  localparam logic [1:0] CfgSettleTicks   = 2'd1;
  localparam logic [1:0] CfgNegReload     = 2'd2;

  localparam int unsigned CfgIdxWidth     = 2;
  localparam int unsigned CfgDataWidth    = 16;
  localparam int unsigned ReloadWidth     = 15;
  localparam int unsigned HoldWidth       = 16;
  localparam int unsigned CoilWidth       = 4;

  localparam logic [HoldWidth-1:0]   PhaseTicksRst  = 16'd5;
  localparam logic [HoldWidth-1:0]   SettleTicksRst = 16'd100;
  localparam logic [ReloadWidth-1:0] NegReloadRst   = 15'd50;

  localparam logic [CoilWidth-1:0] CoilOff = 4'd0;

  typedef struct packed {
    logic inc;
    logic dec;
  } quad_dir_t;

  function automatic logic [CoilWidth-1:0] coil_of(input logic [1:0] phase);
    logic [CoilWidth-1:0] pat;
    case (phase)
      2'd0:    pat = 4'd12;
      2'd1:    pat = 4'd6;
      2'd2:    pat = 4'd3;
      default: pat = 4'd9;
    endcase
    return pat;
  endfunction

endpackage

// ----- hw/rtl/ess_quad_dec.sv -----
// Gray-code quadrature decoder with a saturating signed position update.
// Depends on ess_pkg for the direction struct.
module ess_quad_dec #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                          sample_valid_i,
  input  logic [1:0]                    prev_ab_i,
  input  logic [1:0]                    cur_ab_i,
  input  logic signed [COUNT_WIDTH-1:0] count_i,
  output logic signed [COUNT_WIDTH-1:0] count_o
);

  localparam logic signed [COUNT_WIDTH-1:0] CntMax = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
  localparam logic signed [COUNT_WIDTH-1:0] CntMin = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

  logic [3:0]         trans;
  ess_pkg::quad_dir_t dir;

  assign trans = {prev_ab_i, cur_ab_i};

  always_comb begin
    dir = '0;
    if (sample_valid_i) begin
      case (trans) inside
        4'd2, 4'd4, 4'd11, 4'd13: dir.inc = 1'b1;
        4'd1, 4'd7, 4'd8, 4'd14:  dir.dec = 1'b1;
        default:                  dir = '0;
      endcase
    end
  end

  always_comb begin
    count_o = count_i;
    if (dir.inc && (count_i != CntMax)) begin
      count_o = count_i + COUNT_WIDTH'(1);
    end else if (dir.dec && (count_i != CntMin)) begin
      count_o = count_i - COUNT_WIDTH'(1);
    end
  end

endmodule

// ----- hw/rtl/encoder_set_stepper_step_sequencer_core.sv -----
// Top level of the encoder step setter with a full-step stepper sequencer.
// Depends on ess_pkg and instantiates ess_quad_dec.
//
// Usage: every request on the input channel is one tick carrying the encoder
// A/B levels and the active-low run button. Each accepted request yields
// exactly one result on the output channel: coil drive bits, the LED level
// and a busy flag, all as they stand after that tick.
// The result is registered: it is valid in the cycle after acceptance.
// Throughput is one request per cycle. The state registers double as the
// output register, so a new request is taken in the same cycle that the
// pending result is taken; the input stalls only while a result waits and
// the receiver stalls.
// The configuration channel is always ready and sets the phase hold, the settle hold and
// the reload count; the user must write it only while the block idles (not enforced here).
// Reset clears the count, the decoder history, the sequencer and the
// outputs, and restores the register defaults of 5, 100 and 50.
module encoder_set_stepper_step_sequencer_core #(
  parameter int COUNT_WIDTH = 16,
  parameter int LED_BITS    = 6
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               encoder_a_i,
  input  logic                               encoder_b_i,
  input  logic                               run_button_n_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [ess_pkg::CoilWidth-1:0]      coil_pattern_o,
  output logic [LED_BITS-1:0]                led_level_o,
  output logic                               busy_res_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ess_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  logic [ess_pkg::CfgDataWidth-1:0]   cfg_data_i
);

  localparam int unsigned CntMaxU = 2**(COUNT_WIDTH-1) - 1;
  localparam int unsigned LedTopU = 2**LED_BITS - 1;
  localparam logic [LED_BITS-1:0] LedTop = {LED_BITS{1'b1}};
  localparam logic signed [COUNT_WIDTH-1:0] CntMax = {1'b0, {(COUNT_WIDTH-1){1'b1}}};

  logic [ess_pkg::HoldWidth-1:0]   phase_ticks_q;
  logic [ess_pkg::HoldWidth-1:0]   settle_ticks_q;
  logic [ess_pkg::ReloadWidth-1:0] neg_reload_q;

  ess_pkg::mode_e                  mode_q, mode_d;
  logic signed [COUNT_WIDTH-1:0]   count_q, count_d;
  logic [1:0]                      last_ab_q, last_ab_d;
  logic                            last_valid_q, last_valid_d;
  logic [1:0]                      phase_q, phase_d;
  logic [ess_pkg::HoldWidth-1:0]   hold_q, hold_d;
  logic [LED_BITS-1:0]             led_q, led_d;
  logic [ess_pkg::CoilWidth-1:0]   coil_q, coil_d;
  logic                            out_valid_q;

  logic                            in_accept;
  logic signed [COUNT_WIDTH-1:0]   dec_count;
  logic signed [COUNT_WIDTH-1:0]   start_count;
  logic signed [COUNT_WIDTH-1:0]   step_count;
  logic signed [COUNT_WIDTH-1:0]   reload_sat;
  logic [ess_pkg::HoldWidth-1:0]   phase_hold;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_accept   = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q  <= ess_pkg::PhaseTicksRst;
      settle_ticks_q <= ess_pkg::SettleTicksRst;
      neg_reload_q   <= ess_pkg::NegReloadRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        ess_pkg::CfgPhaseTicks:  phase_ticks_q  <= cfg_data_i;
        ess_pkg::CfgSettleTicks: settle_ticks_q <= cfg_data_i;
        ess_pkg::CfgNegReload:   neg_reload_q   <= cfg_data_i[ess_pkg::ReloadWidth-1:0];
        default: ;
      endcase
    end
  end

  ess_quad_dec #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_quad_dec (
    .sample_valid_i(last_valid_q),
    .prev_ab_i     (last_ab_q),
    .cur_ab_i      ({encoder_a_i, encoder_b_i}),
    .count_i       (count_q),
    .count_o       (dec_count)
  );

  function automatic logic [LED_BITS-1:0] led_clamp(input logic signed [COUNT_WIDTH-1:0] v);
    logic [LED_BITS-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (32'(unsigned'(v)) > 32'(LedTopU)) begin
      r = LedTop;
    end else begin
      r = LED_BITS'(unsigned'(v));
    end
    return r;
  endfunction

  assign reload_sat = (32'(neg_reload_q) > 32'(CntMaxU)) ? CntMax
                                                         : COUNT_WIDTH'(neg_reload_q);
  assign start_count = (dec_count < 0) ? reload_sat : dec_count;
  assign step_count  = count_q - COUNT_WIDTH'(1);
  assign phase_hold  = (phase_ticks_q == '0) ? '0 : phase_ticks_q - 16'd1;

  always_comb begin
    mode_d       = mode_q;
    count_d      = count_q;
    last_ab_d    = last_ab_q;
    last_valid_d = last_valid_q;
    phase_d      = phase_q;
    hold_d       = hold_q;
    led_d        = led_q;
    coil_d       = coil_q;
    unique case (mode_q)
      ess_pkg::ModeIdle: begin
        last_ab_d    = {encoder_a_i, encoder_b_i};
        last_valid_d = 1'b1;
        if (run_button_n_i) begin
          count_d = dec_count;
          led_d   = led_clamp(dec_count);
        end else begin
          count_d = start_count;
          if (start_count > 0) begin
            mode_d  = ess_pkg::ModeStep;
            phase_d = 2'd0;
            coil_d  = ess_pkg::coil_of(2'd0);
            hold_d  = phase_hold;
          end else if (settle_ticks_q == '0) begin
            mode_d = ess_pkg::ModeIdle;
            coil_d = ess_pkg::CoilOff;
            hold_d = '0;
          end else begin
            mode_d = ess_pkg::ModeSettle;
            hold_d = settle_ticks_q - 16'd1;
          end
        end
      end
      ess_pkg::ModeStep: begin
        if (hold_q != '0) begin
          hold_d = hold_q - 16'd1;
        end else if (phase_q != 2'd3) begin
          phase_d = phase_q + 2'd1;
          coil_d  = ess_pkg::coil_of(phase_q + 2'd1);
          hold_d  = phase_hold;
        end else begin
          count_d = step_count;
          led_d   = led_clamp(step_count);
          if (step_count > 0) begin
            phase_d = 2'd0;
            coil_d  = ess_pkg::coil_of(2'd0);
            hold_d  = phase_hold;
          end else if (settle_ticks_q == '0) begin
            mode_d = ess_pkg::ModeIdle;
            coil_d = ess_pkg::CoilOff;
            hold_d = '0;
          end else begin
            mode_d = ess_pkg::ModeSettle;
            hold_d = settle_ticks_q - 16'd1;
          end
        end
      end
      ess_pkg::ModeSettle: begin
        if (hold_q != '0) begin
          hold_d = hold_q - 16'd1;
        end else begin
          coil_d = ess_pkg::CoilOff;
          mode_d = ess_pkg::ModeIdle;
        end
      end
      default: begin
        mode_d = ess_pkg::ModeIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= ess_pkg::ModeIdle;
      count_q      <= '0;
      last_ab_q    <= '0;
      last_valid_q <= 1'b0;
      phase_q      <= '0;
      hold_q       <= '0;
      led_q        <= '0;
      coil_q       <= ess_pkg::CoilOff;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_accept) begin
        mode_q       <= mode_d;
        count_q      <= count_d;
        last_ab_q    <= last_ab_d;
        last_valid_q <= last_valid_d;
        phase_q      <= phase_d;
        hold_q       <= hold_d;
        led_q        <= led_d;
        coil_q       <= coil_d;
        out_valid_q  <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign coil_pattern_o = coil_q;
  assign led_level_o    = led_q;
  assign busy_res_o     = (mode_q != ess_pkg::ModeIdle);

  // While stepping, the coils always carry the pattern of the current phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == ess_pkg::ModeStep) |-> (coil_q == ess_pkg::coil_of(phase_q)))
    else $error("coil pattern does not match phase index");

  // The coils are off whenever the sequencer is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == ess_pkg::ModeIdle) |-> (coil_q == ess_pkg::CoilOff))
    else $error("coils driven while idle");

  // A step is only in progress while steps remain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == ess_pkg::ModeStep) |-> (count_q > 0))
    else $error("stepping with no steps left");

  // Without a request the sequencer state does not move.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_accept |=> $stable(mode_q) && $stable(hold_q) && $stable(count_q))
    else $error("state changed without an accepted request");

endmodule
